// ----- rtl/longest_distinct_run_assert.svh -----
// Assertion macros shared by the longest distinct run block.
// Depends on nothing; included by the top level only.
`ifndef LONGEST_DISTINCT_RUN_ASSERT_SVH
`define LONGEST_DISTINCT_RUN_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LDR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ldr_pkg.sv -----
// Shared constants and types of the longest distinct run block.
// Depends on nothing; used by all other files but ldr_ram and the macros.
package ldr_pkg;

   localparam int SYMBOL_BITS  = 10;
   localparam int MAX_LEN      = 65536;
   localparam int TAG_BITS     = 8;
   localparam int LONGEST_BITS = 17;

   // Table depth, width of a stored position and width of the item counter.
   localparam int TABLE_DEPTH = 1 << SYMBOL_BITS;
   localparam int IDX_BITS    = $clog2(MAX_LEN);
   localparam int CNT_BITS    = $clog2(MAX_LEN + 1);

   localparam logic [TAG_BITS-1:0] TAG_MAX = {TAG_BITS{1'b1}};

   typedef struct packed {
      logic [SYMBOL_BITS-1:0] symbol;
      logic                   first;
      logic                   last;
   } req_item_type;

   typedef struct packed {
      logic [LONGEST_BITS-1:0] longest;
      logic                    overflow;
   } rsp_item_type;

   // One table entry: the case tag that wrote it and the position it holds.
   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic [IDX_BITS-1:0] pos;
   } entry_type;

   typedef struct packed {
      logic                   we;
      logic [SYMBOL_BITS-1:0] addr;
      entry_type              data;
   } mem_wr_type;

   // Status of the tag clearing sweep.
   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic [SYMBOL_BITS-1:0] addr;
   } clr_type;

endpackage

// ----- rtl/ldr_req_if.sv -----
// Input channel of the longest distinct run block: valid, ready and one symbol item.
// Depends on ldr_pkg for the symbol width.
interface ldr_req_if;
   logic                           valid;
   logic                           ready;
   logic [ldr_pkg::SYMBOL_BITS-1:0] symbol;
   logic                           first;
   logic                           last;

   modport source (output valid, output symbol, output first, output last, input ready);
   modport sink (input valid, input symbol, input first, input last, output ready);
endinterface

// ----- rtl/ldr_rsp_if.sv -----
// Result channel of the longest distinct run block: valid, ready and one result item.
// Depends on ldr_pkg for the result width.
interface ldr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ldr_pkg::LONGEST_BITS-1:0] longest;
   logic                            overflow;

   modport source (output valid, output longest, output overflow, input ready);
   modport sink (input valid, input longest, input overflow, output ready);
endinterface

// ----- rtl/ldr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ldr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ldr_clear.sv -----
// Sweep that zeroes every tag of the symbol table, one entry a cycle.
// Depends on ldr_pkg; runs after reset and whenever the case tag wraps.
module ldr_clear (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output ldr_pkg::clr_type clr
);

   logic                            busy_ff, busy_in;
   logic [ldr_pkg::SYMBOL_BITS-1:0] addr_ff, addr_in;
   logic                            at_end;

   assign at_end = (addr_ff == {ldr_pkg::SYMBOL_BITS{1'b1}});

   // Walk the table once, starting at entry zero.
   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (busy_ff) begin
         addr_in = addr_ff + ldr_pkg::SYMBOL_BITS'(1);
         if (at_end) begin
            busy_in = 1'b0;
         end
      end else if (start) begin
         busy_in = 1'b1;
         addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   assign clr.busy = busy_ff;
   assign clr.done = busy_ff && at_end;
   assign clr.addr = addr_ff;

endmodule

// ----- rtl/ldr_scan.sv -----
// Per-item window update: case start, repeat detection, run and best length.
// Depends on ldr_pkg; fed by the input register and the table lookup.
module ldr_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  ldr_pkg::req_item_type item,
   input  ldr_pkg::entry_type    lookup,
   input  logic                  out_ok,
   input  ldr_pkg::clr_type      clr,
   output logic                  fire,
   output logic                  wrap_req,
   output ldr_pkg::mem_wr_type   wr,
   output ldr_pkg::rsp_item_type result
);

   logic [ldr_pkg::TAG_BITS-1:0] case_tag_ff, case_tag_in;
   logic [ldr_pkg::CNT_BITS-1:0] position_ff, position_in;
   logic [ldr_pkg::IDX_BITS-1:0] window_start_ff, window_start_in;
   logic [ldr_pkg::CNT_BITS-1:0] best_ff, best_in;
   logic                         too_long_ff, too_long_in;

   logic                         start;
   logic [ldr_pkg::TAG_BITS-1:0] tag_cur;
   logic [ldr_pkg::CNT_BITS-1:0] pos_cur;
   logic [ldr_pkg::IDX_BITS-1:0] ws_cur;
   logic [ldr_pkg::CNT_BITS-1:0] best_cur;
   logic                         tl_cur;
   logic                         in_range;
   logic                         hit;
   logic [ldr_pkg::IDX_BITS-1:0] ws_new;
   logic [ldr_pkg::CNT_BITS-1:0] run;
   logic [ldr_pkg::CNT_BITS-1:0] pos_nx;
   logic [ldr_pkg::IDX_BITS-1:0] ws_nx;
   logic [ldr_pkg::CNT_BITS-1:0] best_nx;
   logic                         tl_nx;

   // A case opens on a first flag or on any item while no case is open.
   assign start = item.first || (position_ff == '0 && !too_long_ff);

   // A new case at the top tag has to wait for the table tags to be cleared.
   assign wrap_req = item_valid && start && (case_tag_ff == ldr_pkg::TAG_MAX);
   assign fire     = item_valid && !clr.busy && !wrap_req && (!item.last || out_ok);

   // Values seen by this item, after a possible case start.
   always_comb begin
      tag_cur  = start ? case_tag_ff + ldr_pkg::TAG_BITS'(1) : case_tag_ff;
      pos_cur  = start ? '0 : position_ff;
      ws_cur   = start ? '0 : window_start_ff;
      best_cur = start ? '0 : best_ff;
      tl_cur   = start ? 1'b0 : too_long_ff;
   end

   // A repeat inside the window moves the window past the earlier occurrence.
   always_comb begin
      in_range = pos_cur < ldr_pkg::CNT_BITS'(ldr_pkg::MAX_LEN);
      hit      = !start && (lookup.tag == tag_cur) && (lookup.pos >= ws_cur);
      ws_new   = hit ? lookup.pos + ldr_pkg::IDX_BITS'(1) : ws_cur;
      run      = pos_cur - ldr_pkg::CNT_BITS'(ws_new) + ldr_pkg::CNT_BITS'(1);
      if (in_range) begin
         pos_nx  = pos_cur + ldr_pkg::CNT_BITS'(1);
         ws_nx   = ws_new;
         best_nx = (run > best_cur) ? run : best_cur;
         tl_nx   = tl_cur;
      end else begin
         pos_nx  = pos_cur;
         ws_nx   = ws_cur;
         best_nx = best_cur;
         tl_nx   = 1'b1;
      end
   end

   // Table write and result of this item.
   always_comb begin
      wr.we           = fire && in_range;
      wr.addr         = item.symbol;
      wr.data.tag     = tag_cur;
      wr.data.pos     = pos_cur[ldr_pkg::IDX_BITS-1:0];
      result.longest  = ldr_pkg::LONGEST_BITS'(best_nx);
      result.overflow = tl_nx;
   end

   // Next state; the last item of a case closes it.
   always_comb begin
      case_tag_in     = case_tag_ff;
      position_in     = position_ff;
      window_start_in = window_start_ff;
      best_in         = best_ff;
      too_long_in     = too_long_ff;
      if (clr.done) begin
         case_tag_in = '0;
      end else if (fire) begin
         case_tag_in = tag_cur;
         if (item.last) begin
            position_in     = '0;
            window_start_in = '0;
            best_in         = '0;
            too_long_in     = 1'b0;
         end else begin
            position_in     = pos_nx;
            window_start_in = ws_nx;
            best_in         = best_nx;
            too_long_in     = tl_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         case_tag_ff     <= '0;
         position_ff     <= '0;
         window_start_ff <= '0;
         best_ff         <= '0;
         too_long_ff     <= 1'b0;
      end else begin
         case_tag_ff     <= case_tag_in;
         position_ff     <= position_in;
         window_start_ff <= window_start_in;
         best_ff         <= best_in;
         too_long_ff     <= too_long_in;
      end
   end

endmodule

// ----- rtl/longest_distinct_run.sv -----
// Longest run of pairwise distinct symbols per case; one item taken per cycle, bounded by
// one table read and write per item, while no tag clearing runs or is due and the output
// register is free. A last item passes the stage register, its result the output register.
// Reset: a sweep clears all 1024 table tags first, with no item taken meanwhile.
// The same sweep runs again each time the 8-bit case tag wraps, every 255 cases.
// Depends on ldr_pkg, ldr_req_if, ldr_rsp_if, ldr_ram, ldr_clear and ldr_scan.
`include "longest_distinct_run_assert.svh"

module longest_distinct_run (
   input logic        clock,
   input logic        reset,
   ldr_req_if.sink    req_chan,
   ldr_rsp_if.source  rsp_chan
);

   logic                  req_accept;
   logic                  s1_valid_ff, s1_valid_in;
   ldr_pkg::req_item_type s1_item_ff, s1_item_in;
   logic                  fwd_hit_ff, fwd_hit_in;
   ldr_pkg::entry_type    fwd_entry_ff, fwd_entry_in;
   ldr_pkg::entry_type    rd_entry;
   ldr_pkg::entry_type    lookup;
   ldr_pkg::mem_wr_type   scan_wr, mem_wr;
   ldr_pkg::clr_type      clr;
   ldr_pkg::rsp_item_type result;
   logic                  scan_fire;
   logic                  wrap_req;
   logic                  out_ok;
   logic                  rsp_valid_ff, rsp_valid_in;
   ldr_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic [$bits(ldr_pkg::entry_type)-1:0] rd_bits;

   // Take an item when not clearing and the stage register is free or drains this cycle.
   assign req_chan.ready = !clr.busy && (!s1_valid_ff || scan_fire);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign out_ok         = !rsp_valid_ff || rsp_chan.ready;

   // Stage register and forwarding of the write made by the item ahead.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_item_in   = s1_item_ff;
      fwd_hit_in   = fwd_hit_ff;
      fwd_entry_in = fwd_entry_ff;
      if (req_accept) begin
         s1_valid_in       = 1'b1;
         s1_item_in.symbol = req_chan.symbol;
         s1_item_in.first  = req_chan.first;
         s1_item_in.last   = req_chan.last;
         fwd_hit_in        = scan_wr.we && (scan_wr.addr == req_chan.symbol);
         fwd_entry_in      = scan_wr.data;
      end else if (scan_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         fwd_hit_ff  <= fwd_hit_in;
      end
      s1_item_ff   <= s1_item_in;
      fwd_entry_ff <= fwd_entry_in;
   end

   assign rd_entry = ldr_pkg::entry_type'(rd_bits);
   assign lookup   = fwd_hit_ff ? fwd_entry_ff : rd_entry;

   // The clearing sweep owns the write port while it runs.
   always_comb begin
      if (clr.busy) begin
         mem_wr.we   = 1'b1;
         mem_wr.addr = clr.addr;
         mem_wr.data = '0;
      end else begin
         mem_wr = scan_wr;
      end
   end

   ldr_ram #(
      .WIDTH ($bits(ldr_pkg::entry_type)),
      .DEPTH (ldr_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr.we),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_en   (req_accept),
      .rd_addr (req_chan.symbol),
      .rd_data (rd_bits)
   );

   ldr_clear u_clear (
      .clock (clock),
      .reset (reset),
      .start (wrap_req),
      .clr   (clr)
   );

   ldr_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .item       (s1_item_ff),
      .lookup     (lookup),
      .out_ok     (out_ok),
      .clr        (clr),
      .fire       (scan_fire),
      .wrap_req   (wrap_req),
      .wr         (scan_wr),
      .result     (result)
   );

   // Output register: loaded by a last item, emptied when the sink takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (scan_fire && s1_item_ff.last) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.longest  = rsp_item_ff.longest;
   assign rsp_chan.overflow = rsp_item_ff.overflow;

   // No item enters while the tags are being cleared.
   `LDR_ASSERT_IMPLY(a_no_accept_in_clear, clock, reset, req_accept, !clr.busy, "item taken during tag clearing")
   // The table write port never has two writers.
   `LDR_ASSERT_IMPLY(a_single_writer, clock, reset, clr.busy, !scan_fire, "item processed during tag clearing")
   // A finished case always lands in the output register.
   `LDR_ASSERT_NEXT(a_result_loaded, clock, reset, scan_fire && s1_item_ff.last, rsp_chan.valid, "result of a last item lost")

endmodule
